// File: hdl/get_pkg.sv
// ----------------------------------------------------------------------------
// get_pkg
// Shared types, register codes, reset values and gradient helpers for the
// 3x3 gradient edge threshold block.
// ----------------------------------------------------------------------------
package get_pkg;

  // window geometry
  localparam int KERNEL_SIZE  = 3;
  localparam int PIXEL_W      = 8;
  localparam int GRAD_W       = 11;
  localparam int SQ_W         = 20;
  localparam int MAG_W        = 21;
  localparam int CFG_DATA_W   = 11;

  // default frame limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // output pixel codes
  localparam logic [PIXEL_W-1:0] WHITE_VALUE = 8'd255;
  localparam logic [PIXEL_W-1:0] BLACK_VALUE = 8'd0;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2,
    REG_OPERATOR_MODE  = 2'd3
  } reg_index_t;

  // gradient operator select
  typedef enum logic {
    MODE_ROBERTS = 1'b0,
    MODE_PREWITT = 1'b1
  } mode_t;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH     = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT    = 11'd480;
  localparam logic [PIXEL_W-1:0]    RESET_THRESHOLD = 8'd70;
  localparam mode_t                 RESET_MODE      = MODE_PREWITT;

  // 3x3 window, entry r*3+c, r top to bottom, c left to right
  typedef logic [KERNEL_SIZE*KERNEL_SIZE-1:0][PIXEL_W-1:0] window_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  // per-item control carried along the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } item_flags_t;

  // finished result on its way to the output buffer
  typedef struct packed {
    logic               valid;
    logic [PIXEL_W-1:0] edge_pixel;
    logic               frame_last;
  } result_t;

  // prewitt: left column minus right column
  function automatic grad_t prewitt_gx(window_t q);
    logic [9:0] a;
    logic [9:0] b;
    a = 10'(q[0]) + 10'(q[3]) + 10'(q[6]);
    b = 10'(q[2]) + 10'(q[5]) + 10'(q[8]);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // prewitt: top row minus bottom row
  function automatic grad_t prewitt_gy(window_t q);
    logic [9:0] a;
    logic [9:0] b;
    a = 10'(q[0]) + 10'(q[1]) + 10'(q[2]);
    b = 10'(q[6]) + 10'(q[7]) + 10'(q[8]);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // roberts: upper-left minus centre
  function automatic grad_t roberts_gx(window_t q);
    return $signed({3'b000, q[0]}) - $signed({3'b000, q[4]});
  endfunction

  // roberts: centre minus upper-right
  function automatic grad_t roberts_gy(window_t q);
    return $signed({3'b000, q[4]}) - $signed({3'b000, q[2]});
  endfunction

endpackage

// File: hdl/get_pixel_if.sv
// ----------------------------------------------------------------------------
// get_pixel_if
// Pixel stream channel: valid/ready with one grayscale pixel per transaction.
// ----------------------------------------------------------------------------
interface get_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [get_pkg::PIXEL_W-1:0]  pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// File: hdl/get_edge_if.sv
// ----------------------------------------------------------------------------
// get_edge_if
// Edge result channel: valid/ready with the edge pixel and frame end mark.
// ----------------------------------------------------------------------------
interface get_edge_if;
  logic                         valid;
  logic                         ready;
  logic [get_pkg::PIXEL_W-1:0]  edge_pixel;
  logic                         frame_last;

  modport source (output valid, output edge_pixel, output frame_last, input ready);
  modport sink (input valid, input edge_pixel, input frame_last, output ready);
endinterface

// File: hdl/get_cfg_if.sv
// ----------------------------------------------------------------------------
// get_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface get_cfg_if;
  logic                            valid;
  logic                            ready;
  get_pkg::reg_index_t             index;
  logic [get_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/gradient_edge_threshold_3x3_top.sv
// ----------------------------------------------------------------------------
// gradient_edge_threshold_3x3_top
// 3x3 Prewitt / Roberts edge detector with a squared-magnitude threshold.
// ----------------------------------------------------------------------------
// Usage:
//   pixels : grayscale frame in raster order, one 8-bit pixel per transaction.
//   edges  : one result per interior pixel, (H-2)*(W-2) per frame; edge_pixel
//            is 0 when the gradient magnitude exceeds the threshold, else 255,
//            and frame_last marks the final result of the frame.
//   cfg    : register writes (0 width, 1 height, 2 threshold, 3 mode), always
//            ready; write only while no pixel is in flight.
// Throughput is one pixel per clock while the skid entry is empty. The line
// store is a single RAM, read and written back once per pixel.
// On its way to the port a pixel passes line store read, window shift,
// gradient, square and compare, then the output register.
// Reset clears counters, window and registers to their defaults (640x480,
// threshold 70, Prewitt). The line store is not cleared; the first two rows
// fill it before any result uses it.
// When the receiver stalls, one result waits in the output register and one
// in a skid entry; pixels keep being taken until the skid entry fills.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_3x3_top #(
  parameter int MAX_WIDTH  = get_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = get_pkg::DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  get_pixel_if.sink  pixels,
  get_edge_if.source edges,
  get_cfg_if.sink    cfg
);

  logic [get_pkg::CFG_DATA_W-1:0] image_width;
  logic [get_pkg::CFG_DATA_W-1:0] image_height;
  logic [get_pkg::PIXEL_W-1:0]    edge_threshold;
  get_pkg::mode_t                 operator_mode;

  logic                 advance;
  get_pkg::window_t     win;
  get_pkg::item_flags_t win_flags;
  get_pkg::result_t     result;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= get_pkg::RESET_WIDTH;
      image_height   <= get_pkg::RESET_HEIGHT;
      edge_threshold <= get_pkg::RESET_THRESHOLD;
      operator_mode  <= get_pkg::RESET_MODE;
    end else if (cfg.valid) begin
      case (cfg.index)
        get_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg.data;
        get_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg.data;
        get_pkg::REG_EDGE_THRESHOLD: edge_threshold <= cfg.data[get_pkg::PIXEL_W-1:0];
        get_pkg::REG_OPERATOR_MODE:  operator_mode  <= get_pkg::mode_t'(cfg.data[0]);
        default: begin
        end
      endcase
    end
  end

  // counters, line store and window
  get_line_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_line_window (
    .clk          (clk),
    .rst          (rst),
    .pixels       (pixels),
    .advance      (advance),
    .image_width  (image_width),
    .image_height (image_height),
    .win          (win),
    .win_flags    (win_flags)
  );

  // gradient and threshold
  get_grad u_grad (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .win            (win),
    .win_flags      (win_flags),
    .operator_mode  (operator_mode),
    .edge_threshold (edge_threshold),
    .result         (result)
  );

  // output register and skid entry
  get_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .result  (result),
    .advance (advance),
    .edges   (edges)
  );

endmodule

// File: hdl/get_ram.sv
// ----------------------------------------------------------------------------
// get_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module get_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/get_line_window.sv
// ----------------------------------------------------------------------------
// get_line_window
// Raster counters, two-line store in RAM and the 3x3 window registers.
// Each pixel reads its column of the line store, then writes it back shifted.
// ----------------------------------------------------------------------------
module get_line_window #(
  parameter int MAX_WIDTH  = get_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = get_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  get_pixel_if.sink                         pixels,
  input  logic                              advance,
  input  logic [get_pkg::CFG_DATA_W-1:0]    image_width,
  input  logic [get_pkg::CFG_DATA_W-1:0]    image_height,
  output get_pkg::window_t                  win,
  output get_pkg::item_flags_t              win_flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RI = RW + 1;
  localparam int PW = get_pkg::PIXEL_W;

  // clamped frame size
  logic [WW-1:0] wc;
  logic [HW-1:0] hc;

  // raster position of the next pixel
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_a;
  logic [RW-1:0] row_a;
  logic [RI-1:0] row_i;
  logic [WW-1:0] col_i;
  logic [RI-1:0] row_i2;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          produce;
  logic          last;
  logic          accept;

  // read stage
  logic          s1_busy;
  logic          s1_produce;
  logic          s1_last;
  logic [PW-1:0] s1_px;
  logic [CW-1:0] s1_addr;

  // line store port, low byte is the row above, high byte two rows above
  logic          ram_we;
  logic [2*PW-1:0] ram_rdata;
  logic [PW-1:0] mid;
  logic [PW-1:0] top;

  assign accept       = pixels.valid && advance;
  assign pixels.ready = advance;

  // clamp sizes to the supported range
  always_comb begin
    if (image_width < get_pkg::CFG_DATA_W'(get_pkg::KERNEL_SIZE)) begin
      wc = WW'(get_pkg::KERNEL_SIZE);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      wc = WW'(MAX_WIDTH);
    end else begin
      wc = WW'(image_width);
    end
    if (image_height < get_pkg::CFG_DATA_W'(get_pkg::KERNEL_SIZE)) begin
      hc = HW'(get_pkg::KERNEL_SIZE);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      hc = HW'(MAX_HEIGHT);
    end else begin
      hc = HW'(image_height);
    end
  end

  // position of this pixel, with wrap if the size shrank, and the next one
  always_comb begin
    col_a = col;
    row_i = RI'(row);
    if (WW'(col) >= wc) begin
      col_a = '0;
      row_i = RI'(row) + RI'(1);
    end
    if (row_i >= RI'(hc)) begin
      row_a = '0;
    end else begin
      row_a = row_i[RW-1:0];
    end

    produce = (row_a >= RW'(2)) && (col_a >= CW'(2));
    last    = (WW'(col_a) == wc - WW'(1)) && (HW'(row_a) == hc - HW'(1));

    col_i  = WW'(col_a) + WW'(1);
    row_i2 = RI'(row_a) + RI'(1);
    if (col_i >= wc) begin
      col_next = '0;
      if (row_i2 >= RI'(hc)) begin
        row_next = '0;
      end else begin
        row_next = row_i2[RW-1:0];
      end
    end else begin
      col_next = col_i[CW-1:0];
      row_next = row_a;
    end
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // read stage control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_busy <= 1'b0;
    end else if (advance) begin
      s1_busy <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= pixels.pixel_value;
      s1_addr    <= col_a;
      s1_produce <= produce;
      s1_last    <= last;
    end
  end

  assign ram_we = advance && s1_busy;
  assign mid    = ram_rdata[PW-1:0];
  assign top    = ram_rdata[2*PW-1:PW];

  get_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_addr),
    .wr_data ({mid, s1_px}),
    .rd_en   (accept),
    .rd_addr (col_a),
    .rd_data (ram_rdata)
  );

  // window shift and flags for the gradient stage
  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      win_flags <= '0;
    end else if (advance) begin
      win_flags.valid <= s1_busy && s1_produce;
      win_flags.last  <= s1_last;
      if (s1_busy) begin
        for (int r = 0; r < get_pkg::KERNEL_SIZE; r++) begin
          win[r*3]   <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
        end
        win[2] <= top;
        win[5] <= mid;
        win[8] <= s1_px;
      end
    end
  end

  // consecutive pixels never touch the same column in one cycle
  a_addr_apart: assert property (@(posedge clk) disable iff (rst)
    (accept && ram_we) |-> (col_a != s1_addr))
    else $error("line store read and write hit the same column");

  // the counter always lands inside the row it was stepped against
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (WW'(col) < $past(wc)))
    else $error("column counter left the frame width");

endmodule

// File: hdl/get_grad.sv
// ----------------------------------------------------------------------------
// get_grad
// Gradient pair and square registers, then a combinational threshold compare.
// ----------------------------------------------------------------------------
module get_grad (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  get_pkg::window_t              win,
  input  get_pkg::item_flags_t          win_flags,
  input  get_pkg::mode_t                operator_mode,
  input  logic [get_pkg::PIXEL_W-1:0]   edge_threshold,
  output get_pkg::result_t              result
);

  localparam int SQ_W  = get_pkg::SQ_W;
  localparam int MAG_W = get_pkg::MAG_W;
  localparam int PW    = get_pkg::PIXEL_W;

  get_pkg::item_flags_t s3_flags;
  get_pkg::item_flags_t s4_flags;
  get_pkg::grad_t       gx;
  get_pkg::grad_t       gy;
  get_pkg::grad_t       gx_sel;
  get_pkg::grad_t       gy_sel;
  logic signed [2*get_pkg::GRAD_W-1:0] gx_sq;
  logic signed [2*get_pkg::GRAD_W-1:0] gy_sq;
  logic [SQ_W-1:0]      sqx;
  logic [SQ_W-1:0]      sqy;
  logic [2*PW-1:0]      thr_sq;
  logic [MAG_W-1:0]     mag2;

  // operator select
  always_comb begin
    if (operator_mode == get_pkg::MODE_PREWITT) begin
      gx_sel = get_pkg::prewitt_gx(win);
      gy_sel = get_pkg::prewitt_gy(win);
    end else begin
      gx_sel = get_pkg::roberts_gx(win);
      gy_sel = get_pkg::roberts_gy(win);
    end
  end

  // threshold squared, follows the register
  always_ff @(posedge clk) begin
    thr_sq <= edge_threshold * edge_threshold;
  end

  // control of the gradient and square stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_flags <= '0;
      s4_flags <= '0;
    end else if (advance) begin
      s3_flags <= win_flags;
      s4_flags <= s3_flags;
    end
  end

  assign gx_sq = gx * gx;
  assign gy_sq = gy * gy;

  // gradient and square registers
  always_ff @(posedge clk) begin
    if (advance) begin
      gx  <= gx_sel;
      gy  <= gy_sel;
      sqx <= SQ_W'(gx_sq);
      sqy <= SQ_W'(gy_sq);
    end
  end

  // magnitude compare
  assign mag2 = MAG_W'(sqx) + MAG_W'(sqy);

  always_comb begin
    result.valid      = s4_flags.valid;
    result.frame_last = s4_flags.last;
    result.edge_pixel = (mag2 > MAG_W'(thr_sq)) ? get_pkg::BLACK_VALUE
                                                 : get_pkg::WHITE_VALUE;
  end

endmodule

// File: hdl/get_out_buf.sv
// ----------------------------------------------------------------------------
// get_out_buf
// Two-entry output skid buffer; the pipeline keeps moving while one finished
// result waits at the port.
// ----------------------------------------------------------------------------
module get_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  get_pkg::result_t   result,
  output logic               advance,
  get_edge_if.source         edges
);

  logic                         main_valid;
  logic [get_pkg::PIXEL_W-1:0]  main_pixel;
  logic                         main_last;
  logic                         skid_valid;
  logic [get_pkg::PIXEL_W-1:0]  skid_pixel;
  logic                         skid_last;
  logic                         load;
  logic                         pop;

  assign advance = !skid_valid;
  assign load    = result.valid && advance;
  assign pop     = main_valid && edges.ready;

  assign edges.valid      = main_valid;
  assign edges.edge_pixel = main_pixel;
  assign edges.frame_last = main_last;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      main_valid <= skid_valid || load;
      skid_valid <= 1'b0;
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      if (skid_valid) begin
        main_pixel <= skid_pixel;
        main_last  <= skid_last;
      end else begin
        main_pixel <= result.edge_pixel;
        main_last  <= result.frame_last;
      end
    end else if (load) begin
      skid_pixel <= result.edge_pixel;
      skid_last  <= result.frame_last;
    end
  end

  // the spare entry is only used behind a waiting result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held with empty output register");

endmodule

// File: sim/gradient_edge_threshold_3x3_top_test.sv
// ----------------------------------------------------------------------------
// gradient_edge_threshold_3x3_top_test
// Self-checking testbench for the 3x3 Prewitt / Roberts edge threshold block.
// Frames are streamed through the pixel channel with random gaps while the
// edge channel stalls at random. A cycle-free model of the line buffers,
// window and squared-magnitude compare predicts every result. Each result
// is checked field by field against the oldest prediction. Directed frames
// cover register defaults, size clamping, threshold boundaries, both
// operators and size changes in the middle of a frame. Random frames of
// mixed sizes, thresholds, pixel textures and cut-short frames follow.
// ----------------------------------------------------------------------------
module gradient_edge_threshold_3x3_top_test;

  localparam int PIXEL_W        = get_pkg::PIXEL_W;
  localparam int CFG_DATA_W     = get_pkg::CFG_DATA_W;
  localparam int KERNEL_SIZE    = get_pkg::KERNEL_SIZE;
  localparam int SQ_W           = get_pkg::SQ_W;
  localparam int MAG_W          = get_pkg::MAG_W;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int LINE_W         = get_pkg::DEF_MAX_WIDTH;
  localparam int LINE_H         = get_pkg::DEF_MAX_HEIGHT;
  localparam int RANDOM_ITEMS   = 260;
  localparam int PRIME_W        = 40;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 2000000;

  // texture of generated pixel data
  typedef enum int {
    PIX_NOISE,
    PIX_FLAT,
    PIX_BINARY,
    PIX_RAMP
  } pixel_style_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] edge_pixel;
    logic               frame_last;
  } edge_result_t;

  typedef logic [PIXEL_W-1:0] pixel_list_t[$];

  logic clk;
  logic rst;

  get_pixel_if pixels_bus ();
  get_edge_if  edges_bus ();
  get_cfg_if   cfg_bus ();

  gradient_edge_threshold_3x3_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels_bus),
    .edges  (edges_bus),
    .cfg    (cfg_bus)
  );

  // model state: line buffers, window, counters, registers
  logic [PIXEL_W-1:0]    line_copy [2*LINE_W];
  get_pkg::window_t      window_copy;
  int unsigned           col_cnt;
  int unsigned           row_cnt;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [PIXEL_W-1:0]    threshold_reg;
  get_pkg::mode_t        mode_reg;

  edge_result_t expected_edges[$];
  int           error_count = 0;
  int unsigned  items_sent  = 0;
  bit           quiet_flow  = 1'b0;
  int           base_level  = 128;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // idle cycles before the next transaction on either side
  function automatic int pick_gap();
    if (quiet_flow) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v,
                                            int unsigned hi);
    if (v < KERNEL_SIZE) return KERNEL_SIZE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [PIXEL_W-1:0] make_pixel(pixel_style_t style,
                                                    int unsigned idx);
    int level;
    case (style)
      PIX_FLAT: begin
        level = base_level + $urandom_range(0, 8);
        return (level > 255) ? get_pkg::WHITE_VALUE : PIXEL_W'(level);
      end
      PIX_BINARY: return $urandom_range(0, 1) ? get_pkg::WHITE_VALUE : get_pkg::BLACK_VALUE;
      PIX_RAMP:   return PIXEL_W'(base_level + idx * 9);
      default:    return PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // advance the model by one pixel and queue the edge result it makes
  function automatic void predict_edge(logic [PIXEL_W-1:0] px);
    int unsigned        w;
    int unsigned        h;
    int unsigned        col;
    int unsigned        row;
    int unsigned        c;
    int                 r;
    int                 sum_a;
    int                 sum_b;
    logic [PIXEL_W-1:0] mid;
    logic [PIXEL_W-1:0] top;
    get_pkg::grad_t     gx;
    get_pkg::grad_t     gy;
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic [MAG_W-1:0]   mag;
    logic [2*PIXEL_W-1:0] thr_sq;
    edge_result_t       res;

    w = clamp_dim(width_reg, LINE_W);
    h = clamp_dim(height_reg, LINE_H);
    col = col_cnt;
    row = row_cnt;
    // counters left beyond a shrunk size wrap here
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;

    // line buffers and window shift
    c = col % LINE_W;
    mid = line_copy[c];
    top = line_copy[LINE_W + c];
    line_copy[LINE_W + c] = mid;
    line_copy[c] = px;
    for (r = 0; r < KERNEL_SIZE; r++) begin
      window_copy[r*3 + 0] = window_copy[r*3 + 1];
      window_copy[r*3 + 1] = window_copy[r*3 + 2];
    end
    window_copy[2] = top;
    window_copy[5] = mid;
    window_copy[8] = px;

    // gradients and squared-magnitude compare on interior pixels
    if (row >= 2 && col >= 2) begin
      if (mode_reg == get_pkg::MODE_PREWITT) begin
        sum_a = int'(window_copy[0]) + int'(window_copy[3]) + int'(window_copy[6]);
        sum_b = int'(window_copy[2]) + int'(window_copy[5]) + int'(window_copy[8]);
        gx = get_pkg::grad_t'(sum_a - sum_b);
        sum_a = int'(window_copy[0]) + int'(window_copy[1]) + int'(window_copy[2]);
        sum_b = int'(window_copy[6]) + int'(window_copy[7]) + int'(window_copy[8]);
        gy = get_pkg::grad_t'(sum_a - sum_b);
      end else begin
        gx = get_pkg::grad_t'(int'(window_copy[0]) - int'(window_copy[4]));
        gy = get_pkg::grad_t'(int'(window_copy[4]) - int'(window_copy[2]));
      end
      sq_x = gx * gx;
      sq_y = gy * gy;
      mag = sq_x + sq_y;
      thr_sq = threshold_reg * threshold_reg;
      res.edge_pixel = (mag > thr_sq) ? get_pkg::BLACK_VALUE : get_pkg::WHITE_VALUE;
      res.frame_last = (row == h - 1) && (col == w - 1);
      expected_edges.push_back(res);
    end

    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_cnt = col;
    row_cnt = row;
  endfunction

  // one pixel transaction after a random gap
  task automatic send_pixel(logic [PIXEL_W-1:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixels_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixels_bus.valid <= 1'b1;
    pixels_bus.pixel_value <= px;
    @(posedge clk);
    while (!pixels_bus.ready) @(posedge clk);
    predict_edge(px);
    items_sent++;
  endtask

  task automatic send_list(pixel_list_t pixels_in);
    foreach (pixels_in[i]) send_pixel(pixels_in[i]);
  endtask

  // stream pixels until the frame wraps, or stop early when asked
  task automatic stream_frame(pixel_style_t style, int unsigned stop_after);
    int unsigned sent;
    sent = 0;
    do begin
      send_pixel(make_pixel(style, sent));
      sent++;
    end while (!(col_cnt == 0 && row_cnt == 0) && (stop_after == 0 || sent < stop_after));
  endtask

  // drain all results, then allow for pixels still in the pipeline
  task automatic settle();
    pixels_bus.valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write transaction; valid is left high for back-to-back writes
  task automatic cfg_write(get_pkg::reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      get_pkg::REG_IMAGE_WIDTH:    width_reg = value;
      get_pkg::REG_IMAGE_HEIGHT:   height_reg = value;
      get_pkg::REG_EDGE_THRESHOLD: threshold_reg = value[PIXEL_W-1:0];
      get_pkg::REG_OPERATOR_MODE:  mode_reg = get_pkg::mode_t'(value[0]);
      default: begin
      end
    endcase
  endtask

  task automatic program_frame(logic [CFG_DATA_W-1:0] frame_w, logic [CFG_DATA_W-1:0] frame_h,
                               logic [PIXEL_W-1:0] thr, get_pkg::mode_t mode);
    settle();
    cfg_write(get_pkg::REG_IMAGE_WIDTH, frame_w);
    cfg_write(get_pkg::REG_IMAGE_HEIGHT, frame_h);
    cfg_write(get_pkg::REG_EDGE_THRESHOLD, CFG_DATA_W'(thr));
    cfg_write(get_pkg::REG_OPERATOR_MODE, CFG_DATA_W'(mode));
    cfg_bus.valid <= 1'b0;
  endtask

  // default threshold and operator, sizes below the minimum
  task automatic test_reset_defaults();
    settle();
    cfg_write(get_pkg::REG_IMAGE_WIDTH, 11'd2);
    cfg_write(get_pkg::REG_IMAGE_HEIGHT, 11'd0);
    cfg_bus.valid <= 1'b0;
    send_list('{255, 255, 255, 128, 128, 128, 240, 240, 240});
  endtask

  // threshold extremes and the equality boundary on both operators
  task automatic test_operators_thresholds();
    // zero threshold: flat window stays white, a step of one turns black
    program_frame(11'd4, 11'd3, 8'd0, get_pkg::MODE_PREWITT);
    send_list('{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0});
    // roberts at full threshold: both diagonals black, one diagonal at equality white
    program_frame(11'd4, 11'd3, 8'd255, get_pkg::MODE_ROBERTS);
    send_list('{255, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    // prewitt full swing, then a second frame back to back
    program_frame(11'd3, 11'd3, 8'd255, get_pkg::MODE_PREWITT);
    send_list('{255, 0, 0, 255, 0, 0, 255, 0, 0});
    send_list('{255, 255, 255, 0, 0, 0, 0, 0, 0});
  endtask

  // wide short frame, which also fills every line store column that later
  // frames reach, then a narrow tall one
  task automatic test_size_extremes();
    program_frame(CFG_DATA_W'(PRIME_W), 11'd3, 8'd30, get_pkg::MODE_PREWITT);
    base_level = $urandom_range(0, 247);
    stream_frame(PIX_FLAT, 0);
    program_frame(11'd3, 11'd12, 8'd6, get_pkg::MODE_ROBERTS);
    base_level = $urandom_range(0, 247);
    stream_frame(PIX_FLAT, 0);
  endtask

  // width and height shrunk below the counters in the middle of a frame
  task automatic test_mid_frame_resize();
    program_frame(11'd8, 11'd6, 8'd40, get_pkg::MODE_PREWITT);
    stream_frame(PIX_NOISE, 29);
    settle();
    cfg_write(get_pkg::REG_IMAGE_WIDTH, 11'd4);
    cfg_bus.valid <= 1'b0;
    base_level = 20;
    stream_frame(PIX_RAMP, 0);

    program_frame(11'd5, 11'd8, 8'd100, get_pkg::MODE_ROBERTS);
    stream_frame(PIX_BINARY, 27);
    settle();
    cfg_write(get_pkg::REG_IMAGE_HEIGHT, 11'd4);
    cfg_bus.valid <= 1'b0;
    stream_frame(PIX_NOISE, 0);
  endtask

  // random frames, some of them cut short before a new setting
  task automatic test_random_frames();
    int unsigned  start;
    int unsigned  frame_w;
    int unsigned  frame_h;
    int unsigned  thr;
    int unsigned  stop_after;
    pixel_style_t style;

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      quiet_flow = ($urandom_range(0, 3) == 0);
      if (!(col_cnt == 0 && row_cnt == 0) || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       frame_w = $urandom_range(0, 2);
          1:       frame_w = $urandom_range(13, PRIME_W);
          default: frame_w = $urandom_range(3, 12);
        endcase
        frame_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        case ($urandom_range(0, 5))
          0:       thr = 0;
          1:       thr = 255;
          default: thr = $urandom_range(0, 255);
        endcase
        program_frame(CFG_DATA_W'(frame_w), CFG_DATA_W'(frame_h), PIXEL_W'(thr),
                      get_pkg::mode_t'($urandom_range(0, 1)));
      end
      style = pixel_style_t'($urandom_range(0, 3));
      base_level = $urandom_range(0, 255);
      stop_after = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0;
      stream_frame(style, stop_after);
    end
    quiet_flow = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst && edges_bus.valid && edges_bus.ready) begin
      if (expected_edges.size() == 0) begin
        $error("unexpected edge transaction: edge_pixel %0d frame_last %0d",
               edges_bus.edge_pixel, edges_bus.frame_last);
        error_count++;
      end else begin
        want = expected_edges.pop_front();
        if (edges_bus.edge_pixel !== want.edge_pixel) begin
          $error("edge_pixel mismatch: expected %0d, actual %0d",
                 want.edge_pixel, edges_bus.edge_pixel);
          error_count++;
        end
        if (edges_bus.frame_last !== want.frame_last) begin
          $error("frame_last mismatch: expected %0d, actual %0d",
                 want.frame_last, edges_bus.frame_last);
          error_count++;
        end
      end
    end
  end

  // edge receiver with random stalls
  initial begin
    int stall;
    edges_bus.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        edges_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      edges_bus.ready <= 1'b1;
      @(posedge clk);
      while (!edges_bus.valid) @(posedge clk);
    end
  end

  // reset and test sequence
  initial begin
    rst <= 1'b1;
    pixels_bus.valid <= 1'b0;
    pixels_bus.pixel_value <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= get_pkg::REG_IMAGE_WIDTH;
    cfg_bus.data <= '0;

    width_reg = get_pkg::RESET_WIDTH;
    height_reg = get_pkg::RESET_HEIGHT;
    threshold_reg = get_pkg::RESET_THRESHOLD;
    mode_reg = get_pkg::RESET_MODE;
    window_copy = '0;
    col_cnt = 0;
    row_cnt = 0;
    foreach (line_copy[i]) line_copy[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_operators_thresholds();
    test_size_extremes();
    test_mid_frame_resize();
    test_random_frames();

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
